// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHK_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

// Implication with a delayed consequent
`define CHK_AFTER2(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("check failed");

`endif

// ===== sv/smer_pkg.sv =====
package smer_pkg;

  // Default sizing
  localparam int HISTORY_DEPTH_DEF = 1024;
  localparam int TAP_COUNT_DEF     = 4;
  localparam int MAX_TAPS          = 4;

  // Field widths
  localparam int SAMPLE_W      = 24;
  localparam int OUT_W         = 29;
  localparam int WEIGHT_W      = 17;
  localparam int DELAY_W       = 10;
  localparam int SIGN_W        = 8;
  localparam int DELAY_TABLE_W = 40;
  localparam int TAP_IDX_W     = 2;

  // Datapath widths: 24 x 18 signed product, four-term sum
  localparam int PROD_W      = 42;
  localparam int ACC_W       = 43;
  localparam int ROUND_SHIFT = 14;
  localparam int CNT_W       = 3;

  // Register port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;

  // Reset values and limits
  localparam logic [WEIGHT_W-1:0]      WEIGHT_RESET      = 17'd16384;
  localparam logic [WEIGHT_W-1:0]      WEIGHT_MAX        = 17'd65536;
  localparam logic [SIGN_W-1:0]        SIGN_RESET        = 8'd0;
  localparam logic [DELAY_TABLE_W-1:0] DELAY_TABLE_RESET = 40'd505037389824;
  localparam logic [ACC_W:0]           ROUND_HALF        = 44'd8192;

  // Register map, index = paddr[5:3]
  typedef enum logic [2:0] {
    REG_WEIGHT_0    = 3'd0,
    REG_WEIGHT_1    = 3'd1,
    REG_WEIGHT_2    = 3'd2,
    REG_WEIGHT_3    = 3'd3,
    REG_SIGN_BITS   = 3'd4,
    REG_DELAY_TABLE = 3'd5
  } reg_index_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_RUN    = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

endpackage

// ===== sv/stereo_multitap_early_reflections.sv =====
// Items are taken one at a time: a new item is accepted only once the previous result
//   has been loaded into the output register. One read port per history store and one
//   shared multiply-accumulate per channel, one tap per cycle.
// Reset (rst, synchronous, active high) restores registers and the write pointer,
//   then zeroes both history stores, one entry a cycle; no item is accepted during
//   that pass, register writes are taken throughout.
module stereo_multitap_early_reflections #(
  parameter int HISTORY_DEPTH = smer_pkg::HISTORY_DEPTH_DEF,
  parameter int TAP_COUNT     = smer_pkg::TAP_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [smer_pkg::ADDR_W-1:0]         paddr,
  input  logic [smer_pkg::DATA_W-1:0]         pwdata,
  output logic [smer_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [smer_pkg::SAMPLE_W-1:0] sample_left,
  input  logic signed [smer_pkg::SAMPLE_W-1:0] sample_right,
  // result items
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smer_pkg::OUT_W-1:0]   early_left,
  output logic signed [smer_pkg::OUT_W-1:0]   early_right
);

  localparam int PW = $clog2(HISTORY_DEPTH);
  localparam int EW = (PW > smer_pkg::DELAY_W) ? PW : smer_pkg::DELAY_W;

  // ---------------------------------------------------------------- registers
  logic [smer_pkg::WEIGHT_W-1:0]      tap_weight [smer_pkg::MAX_TAPS];
  logic [smer_pkg::SIGN_W-1:0]        tap_sign_bits;
  logic [smer_pkg::DELAY_TABLE_W-1:0] tap_delay_table;

  logic                 cfg_wr;
  smer_pkg::reg_index_t reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = smer_pkg::reg_index_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < smer_pkg::MAX_TAPS; i++) begin
        tap_weight[i] <= smer_pkg::WEIGHT_RESET;
      end
      tap_sign_bits   <= smer_pkg::SIGN_RESET;
      tap_delay_table <= smer_pkg::DELAY_TABLE_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx) inside
        smer_pkg::REG_WEIGHT_0, smer_pkg::REG_WEIGHT_1,
        smer_pkg::REG_WEIGHT_2, smer_pkg::REG_WEIGHT_3: begin
          tap_weight[paddr[4:3]] <= pwdata[smer_pkg::WEIGHT_W-1:0];
        end
        smer_pkg::REG_SIGN_BITS: begin
          tap_sign_bits <= pwdata[smer_pkg::SIGN_W-1:0];
        end
        smer_pkg::REG_DELAY_TABLE: begin
          tap_delay_table <= pwdata[smer_pkg::DELAY_TABLE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // read-back mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx) inside
      smer_pkg::REG_WEIGHT_0, smer_pkg::REG_WEIGHT_1,
      smer_pkg::REG_WEIGHT_2, smer_pkg::REG_WEIGHT_3: begin
        prdata = smer_pkg::DATA_W'(tap_weight[paddr[4:3]]);
      end
      smer_pkg::REG_SIGN_BITS:   prdata = smer_pkg::DATA_W'(tap_sign_bits);
      smer_pkg::REG_DELAY_TABLE: prdata = smer_pkg::DATA_W'(tap_delay_table);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  smer_pkg::state_t             state;
  logic [smer_pkg::CNT_W-1:0]   cnt;
  logic [PW-1:0]                clr_addr;
  logic [PW-1:0]                wp;
  logic                         in_acc;
  logic                         out_load;
  logic                         issue;
  logic [smer_pkg::TAP_IDX_W-1:0] tap_sel;

  assign in_ready = (state == smer_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == smer_pkg::S_FINISH) && (!out_valid || out_ready);
  assign issue    = (state == smer_pkg::S_RUN) &&
                    (cnt < smer_pkg::CNT_W'(TAP_COUNT));
  assign tap_sel  = cnt[smer_pkg::TAP_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= smer_pkg::S_CLEAR;
      cnt      <= '0;
      clr_addr <= '0;
      wp       <= '0;
    end else begin
      unique case (state)
        smer_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PW'(HISTORY_DEPTH - 1)) begin
            state <= smer_pkg::S_IDLE;
          end
        end
        smer_pkg::S_IDLE: begin
          if (in_acc) begin
            state <= smer_pkg::S_RUN;
            cnt   <= '0;
          end
        end
        smer_pkg::S_RUN: begin
          cnt <= cnt + 1'b1;
          // last tap is accumulated at this edge
          if (cnt == smer_pkg::CNT_W'(TAP_COUNT + 1)) begin
            state <= smer_pkg::S_FINISH;
          end
        end
        smer_pkg::S_FINISH: begin
          if (out_load) begin
            state <= smer_pkg::S_IDLE;
            wp    <= (wp == PW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
          end
        end
        default: state <= smer_pkg::S_CLEAR;
      endcase
    end
  end

  // ---------------------------------------------------------------- tap address
  logic [smer_pkg::DELAY_W-1:0] tap_delay [smer_pkg::MAX_TAPS];
  logic [EW:0] d_ext, d_clamp, wp_ext, rd_full;
  logic [PW-1:0] rd_addr;

  always_comb begin
    for (int i = 0; i < smer_pkg::MAX_TAPS; i++) begin
      tap_delay[i] = tap_delay_table[smer_pkg::DELAY_W*i +: smer_pkg::DELAY_W];
    end
  end

  always_comb begin
    d_ext   = (EW+1)'(tap_delay[tap_sel]);
    d_clamp = (d_ext > (EW+1)'(HISTORY_DEPTH - 1)) ? (EW+1)'(HISTORY_DEPTH - 1) : d_ext;
    wp_ext  = (EW+1)'(wp);
    rd_full = (wp_ext >= d_clamp) ? (wp_ext - d_clamp)
                                  : (wp_ext + (EW+1)'(HISTORY_DEPTH) - d_clamp);
    rd_addr = rd_full[PW-1:0];
  end

  // ---------------------------------------------------------------- history stores
  logic signed [smer_pkg::SAMPLE_W-1:0] left_history  [HISTORY_DEPTH];
  logic signed [smer_pkg::SAMPLE_W-1:0] right_history [HISTORY_DEPTH];
  logic                                 mem_we;
  logic [PW-1:0]                        mem_waddr;
  logic signed [smer_pkg::SAMPLE_W-1:0] wdata_l, wdata_r;
  logic signed [smer_pkg::SAMPLE_W-1:0] rdata_l, rdata_r;

  assign mem_we    = (state == smer_pkg::S_CLEAR) || in_acc;
  assign mem_waddr = (state == smer_pkg::S_CLEAR) ? clr_addr : wp;
  assign wdata_l   = (state == smer_pkg::S_CLEAR) ? '0 : sample_left;
  assign wdata_r   = (state == smer_pkg::S_CLEAR) ? '0 : sample_right;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      left_history[mem_waddr]  <= wdata_l;
      right_history[mem_waddr] <= wdata_r;
    end
    rdata_l <= left_history[rd_addr];
    rdata_r <= right_history[rd_addr];
  end

  // ---------------------------------------------------------------- multiply-accumulate
  logic                               v1, v2;
  logic [smer_pkg::TAP_IDX_W-1:0]     idx1, idx2;
  logic [smer_pkg::WEIGHT_W-1:0]      w_sel;
  logic signed [smer_pkg::PROD_W-1:0] prod_l, prod_r;
  logic signed [smer_pkg::ACC_W-1:0]  acc_l, acc_r;
  logic signed [smer_pkg::ACC_W-1:0]  term_l, term_r;

  // weight above 4.0 is held at 4.0
  assign w_sel = (tap_weight[idx1] > smer_pkg::WEIGHT_MAX) ? smer_pkg::WEIGHT_MAX
                                                           : tap_weight[idx1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= tap_sel;
    idx2   <= idx1;
    prod_l <= rdata_l * $signed({1'b0, w_sel});
    prod_r <= rdata_r * $signed({1'b0, w_sel});
  end

  assign term_l = {{(smer_pkg::ACC_W - smer_pkg::PROD_W){prod_l[smer_pkg::PROD_W-1]}}, prod_l};
  assign term_r = {{(smer_pkg::ACC_W - smer_pkg::PROD_W){prod_r[smer_pkg::PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (v2) begin
      acc_l <= tap_sign_bits[{1'b0, idx2}] ? acc_l - term_l : acc_l + term_l;
      acc_r <= tap_sign_bits[{1'b1, idx2}] ? acc_r - term_r : acc_r + term_r;
    end
  end

  // ---------------------------------------------------------------- rounding and output
  logic signed [smer_pkg::ACC_W:0] rnd_l, rnd_r;
  logic signed [smer_pkg::ACC_W:0] shr_l, shr_r;

  // round to nearest, ties upward, then drop 14 fraction bits
  assign rnd_l = {acc_l[smer_pkg::ACC_W-1], acc_l} + $signed(smer_pkg::ROUND_HALF);
  assign rnd_r = {acc_r[smer_pkg::ACC_W-1], acc_r} + $signed(smer_pkg::ROUND_HALF);
  assign shr_l = rnd_l >>> smer_pkg::ROUND_SHIFT;
  assign shr_r = rnd_r >>> smer_pkg::ROUND_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      early_left  <= shr_l[smer_pkg::OUT_W-1:0];
      early_right <= shr_r[smer_pkg::OUT_W-1:0];
    end
  end

endmodule

// ===== sv/smer_checker.sv =====
`include "assert_macros.svh"

module smer_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          pready,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [smer_pkg::OUT_W-1:0]    early_left,
  input logic [smer_pkg::OUT_W-1:0]    early_right
);

  // register port never stalls
  `CHK_IMPLY(a_pready_high, clk, rst, 1'b1, pready)

  // an accepted item keeps the block busy for the following cycles
  `CHK_NEXT(a_busy_next, clk, rst, in_valid && in_ready, !in_ready)
  `CHK_AFTER2(a_busy_two, clk, rst, in_valid && in_ready, !in_ready)

  // a stalled result item holds
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
            out_valid && $stable(early_left) && $stable(early_right))

endmodule

bind stereo_multitap_early_reflections smer_checker u_smer_checker (.*);

// ===== test/stereo_multitap_early_reflections_tb.sv =====
`timescale 1ns / 1ps

module stereo_multitap_early_reflections_tb;
  import smer_pkg::*;

  localparam int DEPTH         = HISTORY_DEPTH_DEF;
  localparam int TAPS          = TAP_COUNT_DEF;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int STALL_LIMIT   = 6000;
  localparam int SETTLE_CYCLES = 4 * (TAPS + 4);
  localparam int MAX_REPORTS   = 10;
  localparam int DIRECTED_N    = 22;
  localparam longint ROUND_BIAS = longint'(1) <<< (ROUND_SHIFT - 1);

  // Addresses past the register map, written to show they are ignored
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]    early_t;

  typedef struct {
    early_t left;
    early_t right;
  } reflection_t;

  typedef enum int {CFG_KEEP, CFG_EXTREME, CFG_FULL_NEG} cfg_set_t;

  typedef struct {
    cfg_set_t cfg;
    sample_t  left;
    sample_t  right;
    bit       fixed;
    early_t   exp_left;
    early_t   exp_right;
  } stim_row_t;

  // DUT signals
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  sample_t               sample_left = '0;
  sample_t               sample_right = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  early_t                early_left;
  early_t                early_right;

  // Shadow registers and history stores for the predictor
  logic [WEIGHT_W-1:0]      weight_shadow [MAX_TAPS];
  logic [SIGN_W-1:0]        sign_shadow;
  logic [DELAY_TABLE_W-1:0] delay_shadow;
  sample_t                  left_hist [DEPTH];
  sample_t                  right_hist [DEPTH];
  int unsigned              write_pos;

  reflection_t expected_reflections [$];
  reflection_t head_mix;
  int          mismatch_cnt = 0;
  int          stall_left;
  int          idle_cycles = 0;
  bit          calm_phase = 1'b0;

  // Directed items: fresh store first, then the weight, sign and delay extremes
  stim_row_t directed_rows [DIRECTED_N] = '{
    // unit weights, cleared store: only the zero-delay tap sees data
    '{CFG_KEEP, 24'sh7FFFFF, 24'sh800000, 1'b1, 29'sh07FFFFF, 29'sh1F800000},
    '{CFG_KEEP, 24'sh800000, 24'sh7FFFFF, 1'b1, 29'sh1F800000, 29'sh07FFFFF},
    '{CFG_KEEP, 24'sh000000, 24'shFFFFFF, 1'b1, 29'sh0000000, 29'sh1FFFFFFF},
    '{CFG_KEEP, 24'shFFFFFF, 24'sh000001, 1'b1, 29'sh1FFFFFFF, 29'sh0000001},
    '{CFG_KEEP, 24'sh000001, 24'sh000000, 1'b1, 29'sh0000001, 29'sh0000000},
    '{CFG_KEEP, 24'sh555555, 24'shAAAAAA, 1'b1, 29'sh0555555, 29'sh1FAAAAAA},
    '{CFG_KEEP, 24'shAAAAAA, 24'sh555555, 1'b1, 29'sh1FAAAAAA, 29'sh0555555},
    '{CFG_KEEP, 24'sh123456, 24'shEDCBA9, 1'b1, 29'sh0123456, 29'sh1FEDCBA9},
    // weights at 4.0, above 4.0 and zero; mixed signs; delays 0, 1, 2, 1023
    '{CFG_EXTREME, 24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,    24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,    24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,    24'sh7FFFFF, 24'sh800000, 1'b0, '0, '0},
    '{CFG_KEEP,    24'sh000001, 24'shFFFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,    24'shFFFFFF, 24'sh000001, 1'b0, '0, '0},
    // every tap negated at 4.0: four equal samples drive the sum to its limits
    '{CFG_FULL_NEG, 24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh800000, 24'sh7FFFFF, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh7FFFFF, 24'sh800000, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh7FFFFF, 24'sh800000, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh7FFFFF, 24'sh800000, 1'b0, '0, '0},
    '{CFG_KEEP,     24'sh7FFFFF, 24'sh800000, 1'b0, '0, '0}
  };

  stereo_multitap_early_reflections u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_left  (sample_left),
    .sample_right (sample_right),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .early_left   (early_left),
    .early_right  (early_right)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Write the new sample pair, then sum the four weighted, signed taps
  function automatic reflection_t mix_reflections(sample_t l, sample_t r);
    reflection_t res;
    longint      acc_l;
    longint      acc_r;
    longint      prod_l;
    longint      prod_r;
    longint      wgt;
    int unsigned dly;
    int unsigned rd;
    int          i;
    acc_l = 0;
    acc_r = 0;
    left_hist[write_pos]  = l;
    right_hist[write_pos] = r;
    for (i = 0; i < TAPS; i++) begin
      dly = delay_shadow[DELAY_W*i +: DELAY_W];
      if (dly > DEPTH - 1) dly = DEPTH - 1;
      rd  = (write_pos + DEPTH - dly) % DEPTH;
      wgt = (weight_shadow[i] > WEIGHT_MAX) ? longint'(WEIGHT_MAX)
                                             : longint'(weight_shadow[i]);
      prod_l = longint'(left_hist[rd]) * wgt;
      prod_r = longint'(right_hist[rd]) * wgt;
      acc_l += sign_shadow[i] ? -prod_l : prod_l;
      acc_r += sign_shadow[MAX_TAPS + i] ? -prod_r : prod_r;
    end
    write_pos = (write_pos + 1) % DEPTH;
    // round half up to Q.23, then keep the output width
    res.left  = early_t'((acc_l + ROUND_BIAS) >>> ROUND_SHIFT);
    res.right = early_t'((acc_r + ROUND_BIAS) >>> ROUND_SHIFT);
    return res;
  endfunction

  // Mostly no gap, some short, a few long; none at all in a calm phase
  function automatic int pick_gap();
    int roll;
    if (calm_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return 24'sh7FFFFF;
      1:       return 24'sh800000;
      2:       return sample_t'($urandom_range(0, 511)) - 24'sd256;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return WEIGHT_MAX;
      2:       return WEIGHT_W'($urandom_range(65537, 131071));
      3:       return WEIGHT_RESET;
      default: return WEIGHT_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Short delays keep recent samples in play; the full range now and then
  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 10'd1023;
      2:       return DELAY_W'($urandom_range(0, 1023));
      default: return DELAY_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [SIGN_W-1:0] pick_signs();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return SIGN_W'($urandom);
    endcase
  endfunction

  function automatic void note_mismatch(string what, early_t want, early_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endfunction

  // Register write: setup then access, shadow updated once it has landed
  task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3:
        weight_shadow[idx[1:0]] = value[WEIGHT_W-1:0];
      REG_SIGN_BITS:   sign_shadow  = value[SIGN_W-1:0];
      REG_DELAY_TABLE: delay_shadow = value[DELAY_TABLE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_cfg_set(cfg_set_t sel);
    case (sel)
      CFG_EXTREME: begin
        write_reg(REG_WEIGHT_0, 64'(WEIGHT_MAX));
        write_reg(REG_WEIGHT_1, 64'h1_FFFF);
        write_reg(REG_WEIGHT_2, 64'(WEIGHT_MAX) + 64'd1);
        write_reg(REG_WEIGHT_3, '0);
        write_reg(REG_SIGN_BITS, 64'hA5);
        write_reg(REG_DELAY_TABLE, 64'({10'd1023, 10'd2, 10'd1, 10'd0}));
        write_reg(REG_SPARE_6, {$urandom, $urandom});
        write_reg(REG_SPARE_7, {$urandom, $urandom});
      end
      CFG_FULL_NEG: begin
        write_reg(REG_WEIGHT_0, 64'(WEIGHT_MAX));
        write_reg(REG_WEIGHT_1, 64'(WEIGHT_MAX));
        write_reg(REG_WEIGHT_2, 64'(WEIGHT_MAX));
        write_reg(REG_WEIGHT_3, 64'(WEIGHT_MAX));
        write_reg(REG_SIGN_BITS, 64'hFF);
        write_reg(REG_DELAY_TABLE, 64'({10'd3, 10'd2, 10'd1, 10'd0}));
      end
      default: ;
    endcase
  endtask

  // Random settings; junk in the unused upper data bits
  task automatic randomise_cfg();
    logic [DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_WEIGHT_0, {junk[DATA_W-1:WEIGHT_W], pick_weight()});
    write_reg(REG_WEIGHT_1, {junk[DATA_W-1:WEIGHT_W], pick_weight()});
    write_reg(REG_WEIGHT_2, {junk[DATA_W-1:WEIGHT_W], pick_weight()});
    write_reg(REG_WEIGHT_3, {junk[DATA_W-1:WEIGHT_W], pick_weight()});
    write_reg(REG_SIGN_BITS, {junk[DATA_W-1:SIGN_W], pick_signs()});
    write_reg(REG_DELAY_TABLE, {junk[DATA_W-1:DELAY_TABLE_W],
                                pick_delay(), pick_delay(), pick_delay(), pick_delay()});
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE_7, junk);
  endtask

  task automatic drain();
    while (expected_reflections.size() != 0) @(posedge clk);
  endtask

  // Offer one item; predict its result once it has been taken
  task automatic send_samples(sample_t l, sample_t r, bit fixed, early_t fl, early_t fr);
    int          gap;
    reflection_t exp_mix;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_left  <= l;
    sample_right <= r;
    do @(posedge clk); while (!in_ready);
    exp_mix = mix_reflections(l, r);
    if (fixed) begin
      exp_mix.left  = fl;
      exp_mix.right = fr;
    end
    expected_reflections.push_back(exp_mix);
  endtask

  // Receiver: random stalls, compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reflections.size() == 0) begin
          note_mismatch("result with nothing pending (left)", '0, early_left);
        end else begin
          head_mix = expected_reflections.pop_front();
          if (early_left !== head_mix.left)
            note_mismatch("early_left", head_mix.left, early_left);
          if (early_right !== head_mix.right)
            note_mismatch("early_right", head_mix.right, early_right);
        end
      end
      if (stall_left > 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    for (int i = 0; i < MAX_TAPS; i++) weight_shadow[i] = WEIGHT_RESET;
    sign_shadow  = SIGN_RESET;
    delay_shadow = DELAY_TABLE_RESET;
    for (int i = 0; i < DEPTH; i++) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    write_pos = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table; settings change only once the block has gone quiet
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg != CFG_KEEP) begin
        in_valid <= 1'b0;
        drain();
        load_cfg_set(directed_rows[i].cfg);
      end
      send_samples(directed_rows[i].left, directed_rows[i].right, directed_rows[i].fixed,
                   directed_rows[i].exp_left, directed_rows[i].exp_right);
    end

    // random phases, each under fresh settings; one phase runs without gaps
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_valid <= 1'b0;
      drain();
      calm_phase = (ph == 2);
      randomise_cfg();
      repeat (PHASE_ITEMS) send_samples(pick_sample(), pick_sample(), 1'b0, '0, '0);
    end

    in_valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== stereo_multitap_early_reflections.f =====
+incdir+sv
sv/smer_pkg.sv
sv/stereo_multitap_early_reflections.sv
sv/smer_checker.sv
test/stereo_multitap_early_reflections_tb.sv
